// ----- src/bbpc_pkg.sv -----
// Shared types and constants for the Bloch boundary phase copy core.
// Depends on nothing; imported by the core and the testbench.
package bbpc_pkg;

    localparam int POS_W      = 12;
    localparam int DATA_W     = 32;
    localparam int SIZE_W     = 13;
    localparam int CFG_ADDR_W = 3;
    localparam int OP_W       = 2;
    localparam int AXIS_W     = 2;
    localparam int TDATA_W    = 80;
    localparam int CALC_W     = 40;
    localparam int PROD_W     = 64;
    localparam int SUM_W      = 65;
    localparam int FRAC_SHIFT = 30;

    localparam logic [OP_W-1:0] OP_WRITE    = 2'd0;
    localparam logic [OP_W-1:0] OP_READ     = 2'd1;
    localparam logic [OP_W-1:0] OP_BOUNDARY = 2'd2;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    localparam logic FIELD_LAST_TO_FIRST = 1'b0;

    localparam logic [CFG_ADDR_W-1:0] REG_FIELD_TYPE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_AXIS       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SIZE_X     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SIZE_Y     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SIZE_Z     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_SIN  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_COS  = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_CHECK,
        S_DIV,
        S_ADDR,
        S_ADDR2,
        S_RD,
        S_MULT,
        S_SUM,
        S_RDOUT,
        S_OUT
    } state_t;

endpackage

// ----- src/bbpc_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; used for the real and imaginary field stores.
module bbpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/bloch_boundary_phase_copy_core.sv -----
// Top level of the Bloch boundary phase copy core: sequencer, address math and phase product.
// Depends on bbpc_pkg and bbpc_ram (one instance for each field part).
//
//  channel | direction | beat contents
//  s_      | in        | tuser operation; tdata position, real_in, imag_in
//  m_      | out       | tuser error; tdata cell_index, real_out, imag_out
//  cfg_    | in        | register index and write data, always ready
//
// A write or a refused beat goes through S_MUL1, S_MUL2 and S_CHECK to S_OUT; a read adds
// S_RDOUT; a boundary update adds S_ADDR, S_ADDR2, S_RD, S_MULT and S_SUM, and on the y axis
// first S_DIV, where the serial face index divider yields one quotient bit at a time.
// Stores are read via one registered read port (data in the cycle after the address) and written back.
// A new beat is accepted once the previous result has moved to the output register.
// Reset returns control to idle and configuration to its defaults; store contents stay undefined until written.
module bloch_boundary_phase_copy_core #(
    parameter int CELLS = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bbpc_pkg::OP_W-1:0]           s_tuser,   // operation
    input  logic [bbpc_pkg::TDATA_W-1:0]        s_tdata,   // position, real_in, imag_in
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [0:0]                          m_tuser,   // error
    output logic [bbpc_pkg::TDATA_W-1:0]        m_tdata,   // cell_index, real_out, imag_out
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bbpc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [bbpc_pkg::DATA_W-1:0]         cfg_data
);

    import bbpc_pkg::*;

    localparam int AW    = $clog2(CELLS);
    localparam int CNT_W = $clog2(POS_W);
    localparam logic [CALC_W-1:0] CELLS_C = CALC_W'(CELLS);
    localparam logic signed [SUM_W-1:0] ROUND_C = SUM_W'(64'sd1 <<< (FRAC_SHIFT - 1));
    localparam logic signed [SUM_W-FRAC_SHIFT-1:0] MAX_C = (SUM_W-FRAC_SHIFT)'(64'sd2147483647);
    localparam logic signed [SUM_W-FRAC_SHIFT-1:0] MIN_C = (SUM_W-FRAC_SHIFT)'(-64'sd2147483648);

    state_t state_reg, state_next;

    logic                      field_type_reg;
    logic [AXIS_W-1:0]         axis_reg;
    logic [SIZE_W-1:0]         size_x_reg, size_y_reg, size_z_reg;
    logic signed [DATA_W-1:0]  phase_sin_reg, phase_cos_reg;

    logic [OP_W-1:0]           op_reg, op_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [DATA_W-1:0]         re_in_reg, re_in_next, im_in_reg, im_in_next;
    logic [2*SIZE_W-1:0]       p_xy_reg, p_xy_next, p_yz_reg, p_yz_next, p_zx_reg, p_zx_next;
    logic [3*SIZE_W-1:0]       total_reg, total_next;
    logic [SIZE_W-1:0]         rem_reg, rem_next;
    logic [POS_W-1:0]          quo_reg, quo_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [CALC_W-1:0]         base_reg, base_next;
    logic [AW-1:0]             src_reg, src_next, tgt_reg, tgt_next;
    logic signed [PROD_W-1:0]  cr_reg, cr_next, si_reg, si_next;
    logic signed [PROD_W-1:0]  sr_reg, sr_next, ci_reg, ci_next;
    logic [POS_W-1:0]          res_idx_reg, res_idx_next;
    logic [DATA_W-1:0]         res_re_reg, res_re_next, res_im_reg, res_im_next;
    logic                      res_err_reg, res_err_next;
    logic                      m_valid_reg, m_valid_next;
    logic [POS_W-1:0]          m_idx_reg, m_idx_next;
    logic [DATA_W-1:0]         m_re_reg, m_re_next, m_im_reg, m_im_next;
    logic                      m_err_reg, m_err_next;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr, ram_raddr;
    logic [DATA_W-1:0]         ram_wre, ram_wim, ram_rre, ram_rim;

    logic [CALC_W-1:0]         pos_w, total_w, pyz_w, pzx_w, pxy_w, sz_w, quo_w, rem_w;
    logic [SIZE_W:0]           div_trial;
    logic                      div_ge;
    logic                      grid_ok;
    logic signed [SUM_W-1:0]   sum_re, sum_im;
    logic [DATA_W-1:0]         new_re, new_im;

    function automatic logic [DATA_W-1:0] round_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0]              r;
        logic signed [SUM_W-FRAC_SHIFT-1:0]   q;
        r = s + ROUND_C;
        q = r[SUM_W-1:FRAC_SHIFT];
        if (q > MAX_C) begin
            return MAX_C[DATA_W-1:0];
        end else if (q < MIN_C) begin
            return MIN_C[DATA_W-1:0];
        end
        return q[DATA_W-1:0];
    endfunction

    assign pos_w   = CALC_W'(pos_reg);
    assign total_w = CALC_W'(total_reg);
    assign pyz_w   = CALC_W'(p_yz_reg);
    assign pzx_w   = CALC_W'(p_zx_reg);
    assign pxy_w   = CALC_W'(p_xy_reg);
    assign sz_w    = CALC_W'(size_z_reg);
    assign quo_w   = CALC_W'(quo_reg);
    assign rem_w   = CALC_W'(rem_reg);

    assign div_trial = {rem_reg, quo_reg[POS_W-1]};
    assign div_ge    = div_trial >= {1'b0, size_z_reg};

    assign grid_ok = (size_x_reg != '0) && (size_y_reg != '0) && (size_z_reg != '0)
                     && (total_w <= CELLS_C);

    assign sum_re = SUM_W'(cr_reg) - SUM_W'(si_reg);
    assign sum_im = SUM_W'(sr_reg) + SUM_W'(ci_reg);
    assign new_re = round_sat(sum_re);
    assign new_im = round_sat(sum_im);

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = m_err_reg;
    assign m_tdata   = {(TDATA_W - POS_W - 2*DATA_W)'(0), m_im_reg, m_re_reg, m_idx_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_type_reg <= 1'b1;
            axis_reg       <= AXIS_X;
            size_x_reg     <= SIZE_W'(1);
            size_y_reg     <= SIZE_W'(1);
            size_z_reg     <= SIZE_W'(1);
            phase_sin_reg  <= '0;
            phase_cos_reg  <= DATA_W'(32'h4000_0000);
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_FIELD_TYPE: field_type_reg <= cfg_data[0];
                REG_AXIS:       axis_reg       <= cfg_data[AXIS_W-1:0];
                REG_SIZE_X:     size_x_reg     <= cfg_data[SIZE_W-1:0];
                REG_SIZE_Y:     size_y_reg     <= cfg_data[SIZE_W-1:0];
                REG_SIZE_Z:     size_z_reg     <= cfg_data[SIZE_W-1:0];
                REG_PHASE_SIN:  phase_sin_reg  <= cfg_data;
                REG_PHASE_COS:  phase_cos_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        pos_reg     <= pos_next;
        re_in_reg   <= re_in_next;
        im_in_reg   <= im_in_next;
        p_xy_reg    <= p_xy_next;
        p_yz_reg    <= p_yz_next;
        p_zx_reg    <= p_zx_next;
        total_reg   <= total_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        base_reg    <= base_next;
        src_reg     <= src_next;
        tgt_reg     <= tgt_next;
        cr_reg      <= cr_next;
        si_reg      <= si_next;
        sr_reg      <= sr_next;
        ci_reg      <= ci_next;
        res_idx_reg <= res_idx_next;
        res_re_reg  <= res_re_next;
        res_im_reg  <= res_im_next;
        res_err_reg <= res_err_next;
        m_idx_reg   <= m_idx_next;
        m_re_reg    <= m_re_next;
        m_im_reg    <= m_im_next;
        m_err_reg   <= m_err_next;
    end

    always_comb begin
        logic [CALC_W-1:0] s_addr;
        logic [CALC_W-1:0] t_addr;
        logic [CALC_W-1:0] faces;
        logic              face_ok;

        state_next   = state_reg;
        op_next      = op_reg;
        pos_next     = pos_reg;
        re_in_next   = re_in_reg;
        im_in_next   = im_in_reg;
        p_xy_next    = p_xy_reg;
        p_yz_next    = p_yz_reg;
        p_zx_next    = p_zx_reg;
        total_next   = total_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        base_next    = base_reg;
        src_next     = src_reg;
        tgt_next     = tgt_reg;
        cr_next      = cr_reg;
        si_next      = si_reg;
        sr_next      = sr_reg;
        ci_next      = ci_reg;
        res_idx_next = res_idx_reg;
        res_re_next  = res_re_reg;
        res_im_next  = res_im_reg;
        res_err_next = res_err_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_idx_next   = m_idx_reg;
        m_re_next    = m_re_reg;
        m_im_next    = m_im_reg;
        m_err_next   = m_err_reg;
        ram_we       = 1'b0;
        ram_waddr    = tgt_reg;
        ram_wre      = new_re;
        ram_wim      = new_im;
        ram_raddr    = src_reg;
        s_addr       = '0;
        t_addr       = '0;
        faces        = '0;
        face_ok      = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    pos_next   = s_tdata[POS_W-1:0];
                    re_in_next = s_tdata[POS_W +: DATA_W];
                    im_in_next = s_tdata[POS_W+DATA_W +: DATA_W];
                    state_next = S_MUL1;
                end
            end
            S_MUL1: begin
                p_xy_next  = (2*SIZE_W)'(size_x_reg) * (2*SIZE_W)'(size_y_reg);
                p_yz_next  = (2*SIZE_W)'(size_y_reg) * (2*SIZE_W)'(size_z_reg);
                p_zx_next  = (2*SIZE_W)'(size_z_reg) * (2*SIZE_W)'(size_x_reg);
                state_next = S_MUL2;
            end
            S_MUL2: begin
                total_next = (3*SIZE_W)'(p_xy_reg) * (3*SIZE_W)'(size_z_reg);
                state_next = S_CHECK;
            end
            S_CHECK: begin
                res_idx_next = pos_reg;
                res_re_next  = '0;
                res_im_next  = '0;
                res_err_next = 1'b1;
                rem_next     = '0;
                quo_next     = pos_reg;
                cnt_next     = '0;
                ram_raddr    = AW'(pos_reg);
                state_next   = S_OUT;
                if (grid_ok) begin
                    unique case (op_reg) inside
                        OP_WRITE, OP_READ: begin
                            if (pos_w < total_w) begin
                                if (op_reg == OP_WRITE) begin
                                    ram_we       = 1'b1;
                                    ram_waddr    = AW'(pos_reg);
                                    ram_wre      = re_in_reg;
                                    ram_wim      = im_in_reg;
                                    res_re_next  = re_in_reg;
                                    res_im_next  = im_in_reg;
                                    res_err_next = 1'b0;
                                end else begin
                                    state_next = S_RDOUT;
                                end
                            end
                        end
                        OP_BOUNDARY: begin
                            unique case (axis_reg)
                                AXIS_X: begin
                                    faces   = pyz_w;
                                    face_ok = 1'b1;
                                end
                                AXIS_Y: begin
                                    faces   = pzx_w;
                                    face_ok = 1'b1;
                                end
                                AXIS_Z: begin
                                    faces   = pxy_w;
                                    face_ok = 1'b1;
                                end
                                default: begin
                                    face_ok = 1'b0;
                                end
                            endcase
                            if (face_ok && (pos_w < faces)) begin
                                state_next = (axis_reg == AXIS_Y) ? S_DIV : S_ADDR;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                rem_next = div_ge ? SIZE_W'(div_trial - {1'b0, size_z_reg})
                                  : div_trial[SIZE_W-1:0];
                quo_next = {quo_reg[POS_W-2:0], div_ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(POS_W - 1)) begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR: begin
                base_next  = (axis_reg == AXIS_Y) ? quo_w * pyz_w : pos_w * sz_w;
                state_next = S_ADDR2;
            end
            S_ADDR2: begin
                unique case (axis_reg)
                    AXIS_X: begin
                        s_addr = pos_w;
                        t_addr = total_w - pyz_w + pos_w;
                    end
                    AXIS_Y: begin
                        s_addr = base_reg + rem_w;
                        t_addr = base_reg + rem_w + pyz_w - sz_w;
                    end
                    default: begin
                        s_addr = base_reg;
                        t_addr = base_reg + sz_w - CALC_W'(1);
                    end
                endcase
                if (field_type_reg == FIELD_LAST_TO_FIRST) begin
                    src_next = t_addr[AW-1:0];
                    tgt_next = s_addr[AW-1:0];
                end else begin
                    src_next = s_addr[AW-1:0];
                    tgt_next = t_addr[AW-1:0];
                end
                state_next = S_RD;
            end
            S_RD: begin
                ram_raddr  = src_reg;
                state_next = S_MULT;
            end
            S_MULT: begin
                cr_next    = PROD_W'(phase_cos_reg) * PROD_W'($signed(ram_rre));
                si_next    = PROD_W'(phase_sin_reg) * PROD_W'($signed(ram_rim));
                sr_next    = PROD_W'(phase_sin_reg) * PROD_W'($signed(ram_rre));
                ci_next    = PROD_W'(phase_cos_reg) * PROD_W'($signed(ram_rim));
                state_next = S_SUM;
            end
            S_SUM: begin
                ram_we       = 1'b1;
                ram_waddr    = tgt_reg;
                res_idx_next = POS_W'(tgt_reg);
                res_re_next  = new_re;
                res_im_next  = new_im;
                res_err_next = 1'b0;
                state_next   = S_OUT;
            end
            S_RDOUT: begin
                res_re_next  = ram_rre;
                res_im_next  = ram_rim;
                res_err_next = 1'b0;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_idx_next   = res_idx_reg;
                    m_re_next    = res_re_reg;
                    m_im_next    = res_im_reg;
                    m_err_next   = res_err_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    bbpc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS)
    ) u_real_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wre),
        .raddr (ram_raddr),
        .rdata (ram_rre)
    );

    bbpc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS)
    ) u_imag_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wim),
        .raddr (ram_raddr),
        .rdata (ram_rim)
    );

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for bloch_boundary_phase_copy_core: cell writes, reads and
// Bloch boundary updates are predicted in SystemVerilog and compared beat by beat.
// Depends on bbpc_pkg and the core; needs no files or arguments.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bbpc_pkg::*;

    localparam int CELLS = 4096;
    localparam int PERIOD = 20;
    localparam int QUIET_LIMIT = 4000;
    localparam int SHOWN_LIMIT = 10;
    localparam int TAIL_CYCLES = 30;

    localparam logic [OP_W-1:0]   OP_NONE   = 2'd3;
    localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;
    localparam logic [31:0] Q_MIN     = 32'h8000_0000;
    localparam logic [31:0] Q_MAX     = 32'h7fff_ffff;
    localparam logic [31:0] PHASE_ONE = 32'h4000_0000;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
    } cell_beat_t;

    typedef struct packed {
        logic [POS_W-1:0]  cell_idx;
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
        logic              err;
    } cell_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [OP_W-1:0] s_tuser = '0;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [0:0] m_tuser;
    logic [TDATA_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [DATA_W-1:0] cfg_data = '0;

    // Register copies, field stores and the queue of results still owed by the core.
    logic              field_type_r = 1'b1;
    logic [AXIS_W-1:0] axis_r = AXIS_X;
    logic [SIZE_W-1:0] size_x_r = 13'd1;
    logic [SIZE_W-1:0] size_y_r = 13'd1;
    logic [SIZE_W-1:0] size_z_r = 13'd1;
    logic [DATA_W-1:0] phase_sin_r = '0;
    logic [DATA_W-1:0] phase_cos_r = PHASE_ONE;
    logic [DATA_W-1:0] real_cells [CELLS];
    logic [DATA_W-1:0] imag_cells [CELLS];
    bit                filled [CELLS];

    cell_beat_t   pending_beats[$];
    cell_result_t results_due[$];
    cell_beat_t   beat_now;

    int  queued_count = 0;
    int  accepted_count = 0;
    int  checked_count = 0;
    int  refused_count = 0;
    int  boundary_count = 0;
    int  settings_count = 0;
    int  fail_count = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    bit  idle_on = 1'b1;
    bit  run_done = 1'b0;

    bloch_boundary_phase_copy_core #(.CELLS(CELLS)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    always #(PERIOD / 2) aclk = ~aclk;

    function automatic longint grid_cells();
        longint t;
        t = longint'(size_x_r) * longint'(size_y_r) * longint'(size_z_r);
        if (size_x_r == 0 || size_y_r == 0 || size_z_r == 0 || t > CELLS) return 0;
        return t;
    endfunction

    function automatic bit face_cells(input logic [POS_W-1:0] pos, output longint src,
                                      output longint tgt, output longint faces);
        longint sx, sy, sz, i, k, t;
        sx = size_x_r;
        sy = size_y_r;
        sz = size_z_r;
        src = 0;
        tgt = 0;
        faces = 0;
        case (axis_r)
            AXIS_X: begin
                faces = sy * sz;
                tgt = (sx - 1) * sy * sz + pos;
                src = pos;
            end
            AXIS_Y: begin
                faces = sz * sx;
                i = (sz == 0) ? 0 : pos / sz;
                k = (sz == 0) ? 0 : pos % sz;
                tgt = i * sy * sz + (sy - 1) * sz + k;
                src = i * sy * sz + k;
            end
            AXIS_Z: begin
                faces = sx * sy;
                tgt = pos * sz + sz - 1;
                src = pos * sz;
            end
            default: return 0;
        endcase
        if (grid_cells() == 0 || pos >= faces) return 0;
        if (field_type_r == FIELD_LAST_TO_FIRST) begin
            t = src;
            src = tgt;
            tgt = t;
        end
        return 1;
    endfunction

    function automatic logic signed [65:0] q_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [65:0] wa, wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    // Drops the 30 phase fraction bits, rounding half up, and clamps to 32 bits.
    function automatic logic [31:0] round_q30(input logic signed [65:0] acc);
        logic signed [65:0] r;
        r = (acc + 66'sd536870912) >>> FRAC_SHIFT;
        if (r > 66'sd2147483647) return Q_MAX;
        if (r < -66'sd2147483648) return Q_MIN;
        return r[31:0];
    endfunction

    function automatic cell_result_t predict_cell_op(input cell_beat_t b);
        cell_result_t r;
        longint total, src, tgt, faces;
        logic signed [31:0] re, im, c, s;
        r.cell_idx = b.pos;
        r.re = '0;
        r.im = '0;
        r.err = 1'b1;
        total = grid_cells();
        if (total == 0) return r;
        if ((b.op == OP_WRITE || b.op == OP_READ) && b.pos < total) begin
            if (b.op == OP_WRITE) begin
                real_cells[b.pos] = b.re;
                imag_cells[b.pos] = b.im;
            end
            r.re = real_cells[b.pos];
            r.im = imag_cells[b.pos];
            r.err = 1'b0;
        end else if (b.op == OP_BOUNDARY && face_cells(b.pos, src, tgt, faces)) begin
            re = real_cells[src];
            im = imag_cells[src];
            c = phase_cos_r;
            s = phase_sin_r;
            r.re = round_q30(q_mul(c, re) - q_mul(s, im));
            r.im = round_q30(q_mul(s, re) + q_mul(c, im));
            real_cells[tgt] = r.re;
            imag_cells[tgt] = r.im;
            r.cell_idx = tgt[POS_W-1:0];
            r.err = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 7))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return $urandom_range(0, 255) << 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_beat(input logic [OP_W-1:0] op, input longint pos,
                                     input logic [31:0] re, input logic [31:0] im);
        cell_beat_t b;
        longint src, tgt, faces;
        b.op = op;
        b.pos = pos[POS_W-1:0];
        b.re = re;
        b.im = im;
        if (op == OP_WRITE && pos < grid_cells()) filled[pos] = 1'b1;
        if (op == OP_BOUNDARY && face_cells(b.pos, src, tgt, faces)) filled[tgt] = 1'b1;
        pending_beats.push_back(b);
        queued_count++;
    endfunction

    // Mostly well-formed traffic in the grid; a cell that is about to be read, directly
    // or as a boundary source, is written first if it has never been written.
    function automatic void add_random_beat();
        longint total, src, tgt, faces, pos;
        logic [OP_W-1:0] op;
        int pick;
        total = grid_cells();
        pick = $urandom_range(0, 99);
        if (total == 0 || pick < 12) begin
            op = OP_W'($urandom_range(0, 3));
            pos = $urandom_range(0, CELLS - 1);
        end else if (pick < 40) begin
            op = OP_WRITE;
            pos = $urandom_range(0, total - 1);
        end else if (pick < 62) begin
            op = OP_READ;
            pos = $urandom_range(0, total - 1);
        end else begin
            op = OP_BOUNDARY;
            void'(face_cells('0, src, tgt, faces));
            pos = (faces == 0) ? $urandom_range(0, CELLS - 1) : $urandom_range(0, faces - 1);
        end
        if (op == OP_READ && pos < total && !filled[pos])
            add_beat(OP_WRITE, pos, rand_q(), rand_q());
        if (op == OP_BOUNDARY && face_cells(pos[POS_W-1:0], src, tgt, faces) && !filled[src])
            add_beat(OP_WRITE, src, rand_q(), rand_q());
        add_beat(op, pos, rand_q(), rand_q());
    endfunction

    task automatic wait_drained();
        do @(posedge aclk);
        while (accepted_count != queued_count || results_due.size() != 0);
    endtask

    // Called at a rising edge; leaves cfg_valid high for a following write.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            REG_FIELD_TYPE: field_type_r = value[0];
            REG_AXIS:       axis_r = value[AXIS_W-1:0];
            REG_SIZE_X:     size_x_r = value[SIZE_W-1:0];
            REG_SIZE_Y:     size_y_r = value[SIZE_W-1:0];
            REG_SIZE_Z:     size_z_r = value[SIZE_W-1:0];
            REG_PHASE_SIN:  phase_sin_r = value;
            REG_PHASE_COS:  phase_cos_r = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [31:0] ft, input logic [31:0] ax,
                             input logic [31:0] sx, input logic [31:0] sy,
                             input logic [31:0] sz, input logic [31:0] ps,
                             input logic [31:0] pc);
        wait_drained();
        write_reg(REG_FIELD_TYPE, ft);
        write_reg(REG_AXIS, ax);
        write_reg(REG_SIZE_X, sx);
        write_reg(REG_SIZE_Y, sy);
        write_reg(REG_SIZE_Z, sz);
        write_reg(REG_PHASE_SIN, ps);
        write_reg(REG_PHASE_COS, pc);
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    // The sender stops now and then until every owed result has come back.
    task automatic add_random_beats(input int n);
        int left, chunk;
        left = n;
        chunk = $urandom_range(20, 60);
        while (left > 0) begin
            add_random_beat();
            left--;
            chunk--;
            if (chunk == 0) begin
                wait_drained();
                chunk = $urandom_range(20, 60);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                results_due.push_back(predict_cell_op(beat_now));
                if (beat_now.op == OP_BOUNDARY) boundary_count++;
                accepted_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_beats.size() != 0) begin
                    beat_now = pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= beat_now.op;
                    s_tdata <= {4'b0, beat_now.im, beat_now.re, beat_now.pos};
                    if (idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 16);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cell_result_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.cell_idx = m_tdata[POS_W-1:0];
                got.re = m_tdata[POS_W +: DATA_W];
                got.im = m_tdata[POS_W + DATA_W +: DATA_W];
                got.err = m_tuser[0];
                if (results_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= SHOWN_LIMIT)
                        $display("%0t: result beat with none owed: cell %0d re %h im %h err %b",
                                 $realtime, got.cell_idx, got.re, got.im, got.err);
                end else begin
                    want = results_due.pop_front();
                    checked_count++;
                    if (want.err) refused_count++;
                    if (got.cell_idx !== want.cell_idx || got.re !== want.re ||
                        got.im !== want.im || got.err !== want.err) begin
                        fail_count++;
                        if (fail_count <= SHOWN_LIMIT)
                            $display("%0t: mismatch: cell %0d/%0d re %h/%h im %h/%h err %b/%b",
                                     $realtime, want.cell_idx, got.cell_idx, want.re, got.re,
                                     want.im, got.im, want.err, got.err);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 16);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT && !run_done) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        if (!run_done) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: one-cell grid, so the boundary update works in place.
        add_beat(OP_WRITE, 0, Q_MAX, Q_MIN);
        add_beat(OP_READ, 0, '0, '0);
        add_beat(OP_BOUNDARY, 0, '0, '0);
        add_beat(OP_READ, 1, '0, '0);
        add_beat(OP_NONE, CELLS - 1, Q_MAX, Q_MAX);
        add_beat(OP_WRITE, CELLS - 1, Q_MIN, Q_MAX);

        configure(1, AXIS_X, CELLS, 1, 1, Q_MIN, Q_MIN);
        add_beat(OP_WRITE, CELLS - 1, Q_MIN, Q_MIN);
        add_beat(OP_WRITE, 0, Q_MIN, Q_MIN);
        add_beat(OP_BOUNDARY, 0, '0, '0);
        add_beat(OP_READ, CELLS - 1, '0, '0);
        add_beat(OP_BOUNDARY, 1, '0, '0);
        add_random_beats(30);

        configure(0, AXIS_Y, 3, 5, 4, 32'h2000_0000, 32'h376c_f5d1);
        add_random_beats(55);
        configure(1, AXIS_Z, 2, 3, 7, $urandom, $urandom);
        add_random_beats(55);

        configure(0, AXIS_Z, 0, 4, 4, Q_MAX, Q_MAX);
        add_beat(OP_WRITE, 5, Q_MAX, Q_MAX);
        add_beat(OP_READ, 5, '0, '0);
        add_beat(OP_BOUNDARY, 0, '0, '0);
        configure(1, AXIS_X, CELLS, 8191, 1, PHASE_ONE, PHASE_ONE);
        add_beat(OP_WRITE, 0, Q_MAX, Q_MAX);
        add_beat(OP_BOUNDARY, 0, '0, '0);
        add_random_beats(10);

        configure(1, AXIS_NONE, 4, 4, 4, PHASE_ONE, '0);
        add_beat(OP_WRITE, 3, $urandom, $urandom);
        add_beat(OP_READ, 3, '0, '0);
        add_beat(OP_BOUNDARY, 0, '0, '0);

        configure(0, AXIS_Z, 1, 1, CELLS, Q_MAX, Q_MIN);
        add_beat(OP_BOUNDARY, 0, '0, '0);
        add_random_beats(20);
        configure(1, AXIS_X, 1, CELLS, 1, $urandom, $urandom);
        add_random_beats(15);
        configure(0, AXIS_Y, 8, 8, 8, $urandom, $urandom);
        add_random_beats(100);

        configure(1, AXIS_Y, 5, 6, 3, $urandom, $urandom);
        idle_on = 1'b0;
        add_random_beats(100);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        run_done = 1'b1;
        $display("Sent %0d beats (%0d boundary updates) under %0d register settings;",
                 accepted_count, boundary_count, settings_count);
        $display("checked %0d results, %0d of them refused requests.",
                 checked_count, refused_count);
        if (fail_count == 0 && results_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
